// File: rtl/core/fisa_pkg.sv
package fisa_pkg;

   // pool geometry
   localparam int POOL_SIZE   = 1024;
   localparam int INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH = $clog2(POOL_SIZE + 1);

   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type POOL_COUNT = COUNT_WIDTH'(POOL_SIZE);

   // request kind
   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   // result status
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // shift control broadcast to every cell of the stack
   typedef struct packed {
      logic pop;
      logic push;
   } shift_ctrl_type;

endpackage

// File: rtl/core/fisa_if.sv
interface fisa_req_if;
   logic                 valid;
   logic                 ready;
   fisa_pkg::kind_type   kind;
   fisa_pkg::index_type  freed_index;

   modport source (output valid, kind, freed_index, input ready);
   modport sink   (input valid, kind, freed_index, output ready);
endinterface

interface fisa_rsp_if;
   logic                 valid;
   logic                 ready;
   fisa_pkg::index_type  given_index;
   fisa_pkg::status_type status;
   fisa_pkg::count_type  in_use_count;

   modport source (output valid, given_index, status, in_use_count, input ready);
   modport sink   (input valid, given_index, status, in_use_count, output ready);
endinterface

// File: rtl/core/fisa_cell.sv
module fisa_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  fisa_pkg::shift_ctrl_type ctrl,
   input  fisa_pkg::index_type      init_value,
   input  fisa_pkg::index_type      from_prev,
   input  fisa_pkg::index_type      from_next,
   output fisa_pkg::index_type      value
);
   import fisa_pkg::*;

   index_type data_ff;
   index_type data_in;

   // pop moves entries toward the top, push moves them away from it
   always_comb begin
      data_in = data_ff;
      priority if (ctrl.pop) begin
         data_in = from_next;
      end else if (ctrl.push) begin
         data_in = from_prev;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= init_value;
      end else begin
         data_ff <= data_in;
      end
   end

   assign value = data_ff;

endmodule

// File: rtl/core/fisa_chain.sv
module fisa_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  fisa_pkg::shift_ctrl_type ctrl,
   input  fisa_pkg::index_type      push_value,
   output fisa_pkg::index_type      top_value
);
   import fisa_pkg::*;

   index_type cell_data [POOL_SIZE];

   // row of cells, cell 0 holds the next free index to hand out
   for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
      index_type prev_data;
      index_type next_data;

      if (k == 0) begin : g_first
         assign prev_data = push_value;
      end else begin : g_inner_prev
         assign prev_data = cell_data[k-1];
      end

      // the deepest cell only ever holds a stale entry after a pop
      if (k == POOL_SIZE - 1) begin : g_last
         assign next_data = cell_data[k];
      end else begin : g_inner_next
         assign next_data = cell_data[k+1];
      end

      fisa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .init_value (INDEX_WIDTH'(k)),
         .from_prev  (prev_data),
         .from_next  (next_data),
         .value      (cell_data[k])
      );
   end

   assign top_value = cell_data[0];

endmodule

// File: rtl/core/free_index_stack_allocator_unit.sv
// Free-index allocator: hands out indices 0..POOL_SIZE-1 from a stack of free
// indices kept in a row of shift cells, cell 0 always holding the next index
// to give out. After reset the stack holds 0, 1, 2, ... in order and nothing
// is in use. Allocate returns the top index (status exhausted and index zero
// when every index is in use); free pushes the given index back (status
// underflow and no change when nothing is in use). Freed indices are not
// checked, so a duplicate free hands the same index out twice. Every request
// produces one registered response item, and the block takes one request per
// cycle unless stalled: a pop or push is a single shift of every cell at once.
// The response sits in an output register; a new request is taken whenever
// that register is empty or being drained in the same cycle.
module free_index_stack_allocator_unit (
   input logic       clock,
   input logic       reset,
   fisa_req_if.sink   req_if,
   fisa_rsp_if.source rsp_if
);
   import fisa_pkg::*;

   count_type      used_count_ff;
   count_type      used_count_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   index_type      given_index_ff;
   index_type      given_index_in;
   status_type     status_ff;
   status_type     status_in;
   count_type      rsp_count_ff;
   shift_ctrl_type ctrl;
   index_type      top_value;
   logic           accept;
   logic           exhausted;
   logic           empty;

   // handshake
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign exhausted = (used_count_ff == POOL_COUNT);
   assign empty     = (used_count_ff == '0);

   // request decode
   always_comb begin
      ctrl           = '0;
      used_count_in  = used_count_ff;
      given_index_in = '0;
      status_in      = STATUS_OK;
      unique case (req_if.kind)
         KIND_ALLOC: begin
            if (exhausted) begin
               status_in = STATUS_EXHAUSTED;
            end else begin
               ctrl.pop       = accept;
               given_index_in = top_value;
               used_count_in  = used_count_ff + count_type'(1);
            end
         end
         KIND_FREE: begin
            if (empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               ctrl.push     = accept;
               used_count_in = used_count_ff - count_type'(1);
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // stack of free indices
   fisa_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .push_value (req_if.freed_index),
      .top_value  (top_value)
   );

   // output register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            used_count_ff <= used_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         given_index_ff <= given_index_in;
         status_ff      <= status_in;
         rsp_count_ff   <= used_count_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.given_index  = given_index_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.in_use_count = rsp_count_ff;

endmodule

// File: rtl/core/fisa_checker.sv
module fisa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fisa_pkg::index_type  rsp_given_index,
   input fisa_pkg::status_type rsp_status,
   input fisa_pkg::count_type  rsp_in_use_count
);
   import fisa_pkg::*;

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_given_index)
         && $stable(rsp_status) && $stable(rsp_in_use_count))
      else $error("response item changed while stalled");

   // a waiting request item is taken while the output register is empty
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request refused with empty output register");

   // exhausted only with the whole pool in use
   a_exhausted_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EXHAUSTED |-> rsp_in_use_count == POOL_COUNT)
      else $error("exhausted reported with free indices left");

   // underflow only with nothing in use
   a_underflow_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNDERFLOW |-> rsp_in_use_count == '0)
      else $error("underflow reported with indices in use");

   // no index comes with a failed request
   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_given_index == '0)
      else $error("index returned with a failed request");

endmodule

bind free_index_stack_allocator_unit fisa_checker u_fisa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_given_index  (rsp_if.given_index),
   .rsp_status       (rsp_if.status),
   .rsp_in_use_count (rsp_if.in_use_count)
);
